[hdl/ida_pkg.sv]
`default_nettype none
package ida_pkg;

  // averager sizing
  localparam int AVERAGE_COUNT = 5;
  localparam int ADC_BITS      = 12;
  localparam int SAMPLE_W      = 12;
  localparam int AVG_W         = 12;
  localparam int SUM_W         = ADC_BITS + $clog2(AVERAGE_COUNT);
  localparam int CNT_W         = $clog2(AVERAGE_COUNT + 1);

  // divide by AVERAGE_COUNT as multiply by a rounded-up reciprocal
  localparam int DIV_SHIFT = SUM_W + $clog2(AVERAGE_COUNT);
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam int PROD_W    = SUM_W + RECIP_W + AVG_W;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(AVERAGE_COUNT) - 64'd1) / 64'(AVERAGE_COUNT));

  // sample mask in the field width
  localparam logic [SAMPLE_W-1:0] ADC_MASK = SAMPLE_W'((64'd1 << ADC_BITS) - 64'd1);

  // debounce
  localparam int THR_W   = 8;
  localparam int NUM_CH  = 2;
  localparam logic [THR_W-1:0] UP_THR_A_RST = 8'd50;
  localparam logic [THR_W-1:0] DN_THR_A_RST = 8'd50;
  localparam logic [THR_W-1:0] UP_THR_B_RST = 8'd5;
  localparam logic [THR_W-1:0] DN_THR_B_RST = 8'd5;

  // configuration register indexes
  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_UP_THR_A = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DN_THR_A = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_UP_THR_B = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_DN_THR_B = 8'd3;

  // command codes
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ADC  = 1'b1;

  typedef struct packed {
    logic             state;
    logic [THR_W-1:0] up_cnt;
    logic [THR_W-1:0] dn_cnt;
  } chan_t;

  typedef struct packed {
    logic [THR_W-1:0] up_thr;
    logic [THR_W-1:0] dn_thr;
  } thr_t;

endpackage
`default_nettype wire

[hdl/input_debounce_and_adc_average.sv]
`default_nettype none
// the result beat is registered from an accepted input beat and is offered in the next cycle
// throughput: one item per cycle; the single result register is the only stage,
// and input is taken whenever that register is empty or being drained
// reset (rst, synchronous): counters, debounced states, sum, count and average
// go to zero, thresholds to 50/50 (channel A) and 5/5 (channel B), no result pending
module input_debounce_and_adc_average (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ida_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [ida_pkg::THR_W-1:0]        cfg_data,
  // input stream
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [15:0]                      s_axis_tdata,  // [1:0] pin_levels, [13:2] adc_sample, [15:14] zero
  input  wire logic                             s_axis_tuser,  // command
  // result stream
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic [15:0]                           m_axis_tdata,  // [0] debounced_a, [1] debounced_b, [13:2] analog_average, [15:14] zero
  output logic                                  m_axis_tuser   // average_updated
);
  import ida_pkg::*;

  // threshold registers, one set per channel
  thr_t thr [NUM_CH];

  // channel state and averager state
  chan_t              chan      [NUM_CH];
  chan_t              chan_next [NUM_CH];
  logic [SUM_W-1:0]   sample_sum, sample_sum_next;
  logic [CNT_W-1:0]   sample_count, sample_count_next;
  logic [AVG_W-1:0]   average_value, average_value_next;
  logic               updated_next;

  // input unpacking
  logic [1:0]          pin_levels;
  logic [SAMPLE_W-1:0] adc_sample;
  logic                in_beat;

  // divide-by-count product off the stored sum
  logic [PROD_W-1:0]   quot_prod;

  assign pin_levels = s_axis_tdata[1:0];
  assign adc_sample = s_axis_tdata[13:2] & ADC_MASK;

  // config is always taken; the user must write only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  // result register frees up when drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr[0] <= '{up_thr: UP_THR_A_RST, dn_thr: DN_THR_A_RST};
      thr[1] <= '{up_thr: UP_THR_B_RST, dn_thr: DN_THR_B_RST};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_UP_THR_A: thr[0].up_thr <= cfg_data;
        REG_DN_THR_A: thr[0].dn_thr <= cfg_data;
        REG_UP_THR_B: thr[1].up_thr <= cfg_data;
        REG_DN_THR_B: thr[1].dn_thr <= cfg_data;
        default: ;  // indexes beyond the list are dropped
      endcase
    end
  end

  // integrating counter: saturates at threshold, then flips state and clears the other side
  function automatic chan_t debounce_step(chan_t c, logic level, thr_t t);
    chan_t r;
    r = c;
    if (!level) begin
      if (c.up_cnt < t.up_thr) begin
        r.up_cnt = c.up_cnt + THR_W'(1);
      end else begin
        r.state  = 1'b1;
        r.dn_cnt = '0;
      end
    end else begin
      if (c.dn_cnt < t.dn_thr) begin
        r.dn_cnt = c.dn_cnt + THR_W'(1);
      end else begin
        r.state  = 1'b0;
        r.up_cnt = '0;
      end
    end
    return r;
  endfunction

  assign quot_prod = PROD_W'(sample_sum) * PROD_W'(DIV_RECIP);

  always_comb begin
    chan_next[0]       = chan[0];
    chan_next[1]       = chan[1];
    sample_sum_next    = sample_sum;
    sample_count_next  = sample_count;
    average_value_next = average_value;
    updated_next       = 1'b0;
    if (in_beat) begin
      if (s_axis_tuser == CMD_TICK) begin
        chan_next[0] = debounce_step(chan[0], pin_levels[0], thr[0]);
        chan_next[1] = debounce_step(chan[1], pin_levels[1], thr[1]);
      end else if (sample_count < CNT_W'(AVERAGE_COUNT)) begin
        sample_count_next = sample_count + CNT_W'(1);
        sample_sum_next   = sample_sum + SUM_W'(adc_sample);
      end else begin
        // publishing call: its own sample is dropped
        average_value_next = quot_prod[DIV_SHIFT +: AVG_W];
        sample_sum_next    = '0;
        sample_count_next  = '0;
        updated_next       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan[0]       <= '0;
      chan[1]       <= '0;
      sample_sum    <= '0;
      sample_count  <= '0;
      average_value <= '0;
    end else begin
      chan[0]       <= chan_next[0];
      chan[1]       <= chan_next[1];
      sample_sum    <= sample_sum_next;
      sample_count  <= sample_count_next;
      average_value <= average_value_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_beat) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      m_axis_tdata <= {2'b00, average_value_next, chan_next[1].state, chan_next[0].state};
      m_axis_tuser <= updated_next;
    end
  end

  // checks
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    sample_count <= CNT_W'(AVERAGE_COUNT))
    else $error("sample count ran past the averaging length");

  a_tick_no_publish: assert property (@(posedge clk) disable iff (rst)
    in_beat && s_axis_tuser == CMD_TICK |=> !m_axis_tuser)
    else $error("tick beat flagged a new average");

  a_adc_keeps_debounce: assert property (@(posedge clk) disable iff (rst)
    in_beat && s_axis_tuser == CMD_ADC |=> chan[0] == $past(chan[0]) && chan[1] == $past(chan[1]))
    else $error("adc beat changed debounce state");

  a_publish_clears: assert property (@(posedge clk) disable iff (rst)
    in_beat && s_axis_tuser == CMD_ADC && sample_count == CNT_W'(AVERAGE_COUNT)
    |=> sample_count == '0 && sample_sum == '0 && m_axis_tuser)
    else $error("publishing beat did not restart the averager");

endmodule
`default_nettype wire

[dv/tb_input_debounce_and_adc_average.sv]
`timescale 1ns / 1ps
module tb_input_debounce_and_adc_average;
  import ida_pkg::*;

  // generous bound: ~1800 items, each with sender gaps, receiver stalls,
  // one long hold-off and a settle pause per phase stays far below this
  localparam int CYCLE_LIMIT = 200000;
  localparam int PLAN_ROWS   = 25;
  localparam int NUM_PHASES  = 7;

  // one result beat split into its fields
  typedef struct packed {
    logic             deb_a;
    logic             deb_b;
    logic [AVG_W-1:0] avg;
    logic             upd;
  } result_t;

  // one directed row: either a register write or an input beat
  typedef struct {
    bit                      is_cfg;
    logic [CFG_INDEX_W-1:0]  idx;
    logic [THR_W-1:0]        val;
    logic                    cmd;
    logic [1:0]              pins;
    logic [SAMPLE_W-1:0]     smp;
    bit                      typed;
    result_t                 res;
  } plan_row_t;

  localparam result_t NO_RES = '0;

  logic clk = 1'b0;
  logic rst;

  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [THR_W-1:0]       cfg_data;

  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // [1:0] pin_levels, [13:2] adc_sample, [15:14] zero
  logic        s_axis_tuser;   // command

  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [0] debounced_a, [1] debounced_b, [13:2] analog_average
  logic        m_axis_tuser;   // average_updated

  input_debounce_and_adc_average u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // shadow copy of the conditioner: thresholds, integrating counters, debounced
  // states and the five-sample averager
  // ---------------------------------------------------------------------------
  logic [THR_W-1:0]    thr_up    [NUM_CH];
  logic [THR_W-1:0]    thr_dn    [NUM_CH];
  logic [THR_W-1:0]    cnt_up    [NUM_CH];
  logic [THR_W-1:0]    cnt_dn    [NUM_CH];
  logic                pin_state [NUM_CH];
  logic [CNT_W-1:0]    adc_count;
  logic [SUM_W-1:0]    adc_sum;
  logic [AVG_W-1:0]    avg_held;

  result_t conditioned_q [$];   // results still owed by the block, oldest first
  int      errors       = 0;
  int      results_seen = 0;
  int      cycle_count  = 0;
  bit      steady       = 1'b0;  // set during the stretch with no idling on either side

  // advance the shadow state by one input beat and return the result it causes
  function automatic result_t condition_step(input logic cmd, input logic [1:0] pins,
                                             input logic [SAMPLE_W-1:0] smp);
    result_t r;
    r.upd = 1'b0;
    if (cmd == CMD_TICK) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        if (pins[ch] == 1'b0) begin
          // low pin integrates up, then holds the asserted state
          if (cnt_up[ch] < thr_up[ch]) cnt_up[ch]++;
          else begin
            pin_state[ch] = 1'b1;
            cnt_dn[ch]    = '0;
          end
        end else begin
          if (cnt_dn[ch] < thr_dn[ch]) cnt_dn[ch]++;
          else begin
            pin_state[ch] = 1'b0;
            cnt_up[ch]    = '0;
          end
        end
      end
    end else if (adc_count < AVERAGE_COUNT) begin
      adc_count++;
      adc_sum += SUM_W'(smp & ADC_MASK);
    end else begin
      // publishing call: its own sample is dropped
      avg_held  = AVG_W'(adc_sum / AVERAGE_COUNT);
      adc_sum   = '0;
      adc_count = '0;
      r.upd     = 1'b1;
    end
    r.deb_a = pin_state[0];
    r.deb_b = pin_state[1];
    r.avg   = avg_held;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // directed plan: reset state, sample extremes, zero threshold, threshold
  // lowered under a running counter, ignored register indexes
  // ---------------------------------------------------------------------------
  plan_row_t stim_plan [PLAN_ROWS] = '{
    // tick right after reset: nothing asserted, no average yet
    '{1'b0, 8'd0, 8'd0, CMD_TICK, 2'b11, 12'h000, 1'b1, '{1'b0, 1'b0, 12'd0, 1'b0}},
    // five full-scale samples, pin levels ignored
    '{1'b0, 8'd0, 8'd0, CMD_ADC,  2'b00, 12'hFFF, 1'b1, '{1'b0, 1'b0, 12'd0, 1'b0}},
    '{1'b0, 8'd0, 8'd0, CMD_ADC,  2'b00, 12'hFFF, 1'b1, '{1'b0, 1'b0, 12'd0, 1'b0}},
    '{1'b0, 8'd0, 8'd0, CMD_ADC,  2'b00, 12'hFFF, 1'b1, '{1'b0, 1'b0, 12'd0, 1'b0}},
    '{1'b0, 8'd0, 8'd0, CMD_ADC,  2'b00, 12'hFFF, 1'b1, '{1'b0, 1'b0, 12'd0, 1'b0}},
    '{1'b0, 8'd0, 8'd0, CMD_ADC,  2'b00, 12'hFFF, 1'b1, '{1'b0, 1'b0, 12'd0, 1'b0}},
    // sixth call publishes full scale and drops its own zero sample
    '{1'b0, 8'd0, 8'd0, CMD_ADC,  2'b11, 12'h000, 1'b1, '{1'b0, 1'b0, 12'd4095, 1'b1}},
    // zero up thresholds: the first low tick asserts at once
    '{1'b1, REG_UP_THR_A, 8'd0,   CMD_TICK, 2'b00, 12'h000, 1'b0, NO_RES},
    '{1'b1, REG_UP_THR_B, 8'd0,   CMD_TICK, 2'b00, 12'h000, 1'b0, NO_RES},
    '{1'b0, 8'd0, 8'd0, CMD_TICK, 2'b00, 12'hFFF, 1'b1, '{1'b1, 1'b1, 12'd4095, 1'b0}},
    // widest down thresholds, then count a few high ticks
    '{1'b1, REG_DN_THR_A, 8'd255, CMD_TICK, 2'b00, 12'h000, 1'b0, NO_RES},
    '{1'b1, REG_DN_THR_B, 8'd255, CMD_TICK, 2'b00, 12'h000, 1'b0, NO_RES},
    '{1'b0, 8'd0, 8'd0, CMD_TICK, 2'b11, 12'h123, 1'b0, NO_RES},
    '{1'b0, 8'd0, 8'd0, CMD_TICK, 2'b11, 12'h456, 1'b0, NO_RES},
    '{1'b0, 8'd0, 8'd0, CMD_TICK, 2'b11, 12'h789, 1'b0, NO_RES},
    // threshold dropped under the running counter: next high tick releases A
    '{1'b1, REG_DN_THR_A, 8'd1,   CMD_TICK, 2'b00, 12'h000, 1'b0, NO_RES},
    '{1'b0, 8'd0, 8'd0, CMD_TICK, 2'b01, 12'h000, 1'b0, NO_RES},
    // indexes past the register list
    '{1'b1, 8'd4,   8'd255,       CMD_TICK, 2'b00, 12'h000, 1'b0, NO_RES},
    '{1'b1, 8'd255, 8'd0,         CMD_TICK, 2'b00, 12'h000, 1'b0, NO_RES},
    // mixed bit patterns through the averager
    '{1'b0, 8'd0, 8'd0, CMD_ADC,  2'b10, 12'hAAA, 1'b0, NO_RES},
    '{1'b0, 8'd0, 8'd0, CMD_ADC,  2'b01, 12'h555, 1'b0, NO_RES},
    '{1'b0, 8'd0, 8'd0, CMD_ADC,  2'b00, 12'h001, 1'b0, NO_RES},
    '{1'b0, 8'd0, 8'd0, CMD_ADC,  2'b11, 12'h002, 1'b0, NO_RES},
    '{1'b0, 8'd0, 8'd0, CMD_ADC,  2'b00, 12'h800, 1'b0, NO_RES},
    '{1'b0, 8'd0, 8'd0, CMD_ADC,  2'b00, 12'hFFF, 1'b0, NO_RES}
  };

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // offer one beat, record what it must produce once it is taken
  task automatic send_beat(input logic cmd, input logic [1:0] pins,
                           input logic [SAMPLE_W-1:0] smp, input bit typed,
                           input result_t typed_res);
    result_t want;
    while (!steady && $urandom_range(99) < 17) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, smp, pins};
    s_axis_tuser  <= cmd;
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
    want = condition_step(cmd, pins, smp);
    conditioned_q.push_back(typed ? typed_res : want);
  endtask

  // stop offering and wait until every owed result has drained
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (conditioned_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // register write beat; valid stays up so writes can run back to back
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [THR_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      REG_UP_THR_A: thr_up[0] = val;
      REG_DN_THR_A: thr_dn[0] = val;
      REG_UP_THR_B: thr_up[1] = val;
      REG_DN_THR_B: thr_dn[1] = val;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    logic [THR_W-1:0]    thr [4];
    logic                lvl [NUM_CH];
    int                  run_left [NUM_CH];
    int                  span;
    int                  n_items;
    bit                  cfg_busy;
    logic                cmd;
    logic [1:0]          pins;
    logic [SAMPLE_W-1:0] smp;

    rst           <= 1'b1;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_TICK;

    // shadow state as it stands after reset
    thr_up[0] = UP_THR_A_RST;
    thr_dn[0] = DN_THR_A_RST;
    thr_up[1] = UP_THR_B_RST;
    thr_dn[1] = DN_THR_B_RST;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      cnt_up[ch]    = '0;
      cnt_dn[ch]    = '0;
      pin_state[ch] = 1'b0;
      lvl[ch]       = 1'b1;
      run_left[ch]  = 0;
    end
    adc_count = '0;
    adc_sum   = '0;
    avg_held  = '0;
    cfg_busy  = 1'b0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed plan; register writes only once the block has drained
    foreach (stim_plan[i]) begin
      if (stim_plan[i].is_cfg) begin
        if (!cfg_busy) settle();
        write_reg(stim_plan[i].idx, stim_plan[i].val);
        cfg_busy = 1'b1;
      end else begin
        if (cfg_busy) cfg_valid <= 1'b0;
        cfg_busy = 1'b0;
        send_beat(stim_plan[i].cmd, stim_plan[i].pins, stim_plan[i].smp,
                  stim_plan[i].typed, stim_plan[i].res);
      end
    end

    // random phases, each under its own threshold setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: foreach (thr[r]) thr[r] = 8'd0;
        1: foreach (thr[r]) thr[r] = 8'd255;
        2: foreach (thr[r]) thr[r] = 8'd1;
        6: thr = '{8'd255, 8'd0, 8'($urandom_range(255)), 8'($urandom_range(255))};
        default: foreach (thr[r]) thr[r] = 8'($urandom_range(10));
      endcase
      span = 0;
      foreach (thr[r]) if (thr[r] > span) span = thr[r];

      // sender waits here until every owed result has come back
      settle();
      write_reg(REG_UP_THR_A, thr[0]);
      write_reg(REG_DN_THR_A, thr[1]);
      write_reg(REG_UP_THR_B, thr[2]);
      write_reg(REG_DN_THR_B, thr[3]);
      if ($urandom_range(1))
        write_reg(8'($urandom_range(REG_DN_THR_B + 1, 255)), 8'($urandom_range(255)));
      cfg_valid <= 1'b0;

      // phase 2 runs with no idling on either side
      steady  = (p == 2);
      n_items = 100 + 2 * span;

      for (int k = 0; k < n_items; k++) begin
        cmd = ($urandom_range(99) < 30) ? CMD_ADC : CMD_TICK;
        // held pin levels with run lengths around the thresholds, so the
        // integrators actually reach and pass them
        for (int ch = 0; ch < NUM_CH; ch++) begin
          if (cmd == CMD_TICK) begin
            if (run_left[ch] == 0) begin
              lvl[ch]      = 1'($urandom_range(1));
              run_left[ch] = $urandom_range(1, 2 * span + 3);
            end
            run_left[ch]--;
          end
        end
        pins = {lvl[1], lvl[0]};
        // occasional glitch, and random levels on ADC beats where they are ignored
        if (cmd == CMD_ADC || $urandom_range(99) < 8) pins = 2'($urandom_range(3));
        if ($urandom_range(9) == 0) smp = $urandom_range(1) ? 12'hFFF : 12'h000;
        else smp = 12'($urandom_range(4095));
        send_beat(cmd, pins, smp, 1'b0, NO_RES);
      end
      steady = 1'b0;
    end

    // drain, then allow the result register to settle
    s_axis_tvalid <= 1'b0;
    while (conditioned_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // output side: random stalls, one long hold-off that backs up the input
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int      hold_left;
    bit      hold_done;
    result_t want;
    result_t got;

    hold_left = 0;
    hold_done = 1'b0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[0], m_axis_tdata[1], m_axis_tdata[13:2], m_axis_tuser};
        results_seen++;
        if (conditioned_q.size() == 0) begin
          errors++;
          $error("result beat with no expected result waiting");
        end else begin
          want = conditioned_q.pop_front();
          if (got.deb_a !== want.deb_a) begin
            errors++;
            $error("debounced_a: expected %0d, got %0d", want.deb_a, got.deb_a);
          end
          if (got.deb_b !== want.deb_b) begin
            errors++;
            $error("debounced_b: expected %0d, got %0d", want.deb_b, got.deb_b);
          end
          if (got.avg !== want.avg) begin
            errors++;
            $error("analog_average: expected %0d, got %0d", want.avg, got.avg);
          end
          if (got.upd !== want.upd) begin
            errors++;
            $error("average_updated: expected %0d, got %0d", want.upd, got.upd);
          end
        end
      end
      // long hold-off in the middle of the widest-threshold phase
      if (results_seen == 600 && !hold_done) begin
        hold_left = 200;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= steady || ($urandom_range(99) >= 17);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule

[input_debounce_and_adc_average.f]
hdl/ida_pkg.sv
hdl/input_debounce_and_adc_average.sv
dv/tb_input_debounce_and_adc_average.sv
